// File: hdl/srsg_pkg.sv
// Shared types and constants of the stepper ramp step generator.
// Holds field widths, register indexes, reset values and controller/datapath links.
// No dependencies.
`default_nettype none
package srsg_pkg;

	localparam int POS_W     = 16;
	localparam int SPEED_W   = 16;
	localparam int ACCEL_W   = 12;
	localparam int DIVISOR_W = 12;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int IVL_W     = 20;
	localparam int ELAPSED_W = 21;

	localparam int POSITIONS_DEF = 1600;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_STEP    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DECEL_DIVISOR = 2'd3;

	localparam logic [SPEED_W-1:0]   MIN_SPEED_RST     = 16'd200;
	localparam logic [SPEED_W-1:0]   MAX_SPEED_RST     = 16'd2000;
	localparam logic [ACCEL_W-1:0]   ACCEL_STEP_RST    = 12'd10;
	localparam logic [DIVISOR_W-1:0] DECEL_DIVISOR_RST = 12'd10;
	localparam logic [IVL_W-1:0]     INTERVAL_RST      = 20'd5000;

	// Microseconds per second, the dividend of the interval division
	localparam logic [IVL_W-1:0] US_PER_SECOND = 20'd1000000;

	typedef struct packed {
		logic capture;
		logic exec_set;
		logic exec_tick;
		logic mul;
		logic step;
		logic div_start;
		logic load_interval;
		logic emit;
	} srsg_cmd_t;

	typedef struct packed {
		logic op_set;
		logic at_target;
		logic interval_due;
		logic div_done;
		logic out_free;
	} srsg_status_t;

endpackage
`default_nettype wire

// File: hdl/srsg_item_if.sv
// Input channel of the step generator: valid/ready handshake carrying one item.
// Depends on srsg_pkg for the field widths.
`default_nettype none
interface srsg_item_if
	import srsg_pkg::*;
;
	logic             valid;
	logic             ready;
	logic             op;
	logic [POS_W-1:0] target_position;

	modport source (output valid, output op, output target_position, input ready);
	modport sink (input valid, input op, input target_position, output ready);
endinterface
`default_nettype wire

// File: hdl/srsg_result_if.sv
// Output channel of the step generator: valid/ready handshake carrying one result.
// Depends on srsg_pkg for the field widths.
`default_nettype none
interface srsg_result_if
	import srsg_pkg::*;
;
	logic             valid;
	logic             ready;
	logic             step_pulse;
	logic             direction;
	logic             moving;
	logic [POS_W-1:0] position;

	modport source (output valid, output step_pulse, output direction, output moving,
		output position, input ready);
	modport sink (input valid, input step_pulse, input direction, input moving,
		input position, output ready);
endinterface
`default_nettype wire

// File: hdl/stepper_ramp_step_generator.sv
// Trapezoidal ramp step generator for a wrap-around rotary axis.
// A set item or a tick without a step goes from the execute state to the output state;
// a tick that steps passes the multiply, step and division states in between.
// One item at a time: a new item is accepted only back in the idle state.
// Reset (arst_n low, asynchronous): config and axis registers take their defaults, the
// axis sits at position 0 ascending and stopped, with speed 200 and interval 5000 us.
`default_nettype none
module stepper_ramp_step_generator
	import srsg_pkg::*;
#(
	// Number of positions on the circle, 4 to 65536
	parameter int POSITIONS = POSITIONS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	srsg_item_if.sink                 item,
	srsg_result_if.source             result
);

	// The controller steps each accepted word through the datapath: an execute
	// state that handles a set or the tick bookkeeping, and for a step a multiply
	// state for the deceleration test, a ramp-and-move state and the division that
	// turns the new speed into the next step interval. The result register in the
	// datapath holds a finished word until the sink takes it, and a new word may be
	// accepted meanwhile; the controller waits only on the divider and the output state.

	srsg_cmd_t    cmd;
	srsg_status_t status;

	srsg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.status   (status),
		.cmd      (cmd)
	);

	srsg_dpath #(
		.POSITIONS (POSITIONS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_op          (item.op),
		.in_target      (item.target_position),
		.cmd            (cmd),
		.status         (status),
		.out_ready      (result.ready),
		.out_valid      (result.valid),
		.out_step_pulse (result.step_pulse),
		.out_direction  (result.direction),
		.out_moving     (result.moving),
		.out_position   (result.position)
	);

endmodule
`default_nettype wire

// File: hdl/srsg_div.sv
// Restoring divider that works out the step interval, one quotient bit a cycle.
// Depends on srsg_pkg for the dividend and widths.
`default_nettype none
module srsg_div
	import srsg_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [SPEED_W-1:0] divisor,
	output logic                    done,
	output logic [IVL_W-1:0]        quotient
);

	localparam int CNT_W = $clog2(IVL_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(IVL_W - 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SPEED_W-1:0] dvs_q;
	logic [SPEED_W-1:0] rem_q;
	logic [IVL_W-1:0]   quo_q;
	logic [SPEED_W+1:0] trial;

	// Bring down the next dividend bit and try to subtract
	assign trial = {1'b0, rem_q, quo_q[IVL_W-1]} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= US_PER_SECOND;
		end else if (busy_q) begin
			if (!trial[SPEED_W+1]) begin
				rem_q <= trial[SPEED_W-1:0];
				quo_q <= {quo_q[IVL_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[SPEED_W-2:0], quo_q[IVL_W-1]};
				quo_q <= {quo_q[IVL_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

// File: hdl/srsg_dpath.sv
// Datapath of the step generator: configuration, axis state, ramp arithmetic, result register.
// Depends on srsg_pkg and srsg_div.
`default_nettype none
module srsg_dpath
	import srsg_pkg::*;
#(
	parameter int POSITIONS = POSITIONS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_op,
	input  wire logic [POS_W-1:0]     in_target,
	input  wire srsg_cmd_t            cmd,
	output srsg_status_t              status,
	input  wire logic                 out_ready,
	output logic                      out_valid,
	output logic                      out_step_pulse,
	output logic                      out_direction,
	output logic                      out_moving,
	output logic [POS_W-1:0]          out_position
);

	localparam int PW = POS_W + 1;
	localparam logic [PW-1:0] POS_N    = PW'(POSITIONS);
	localparam logic [PW-1:0] POS_LAST = PW'(POSITIONS - 1);
	localparam logic [PW-1:0] HALF     = PW'(POSITIONS / 2);
	localparam int PROD_W = PW + DIVISOR_W;

	// Configuration registers
	logic [SPEED_W-1:0]   min_speed_q;
	logic [SPEED_W-1:0]   max_speed_q;
	logic [ACCEL_W-1:0]   accel_step_q;
	logic [DIVISOR_W-1:0] decel_div_q;

	// Axis state
	logic [POS_W-1:0]     cur_q;
	logic [POS_W-1:0]     goal_q;
	logic [SPEED_W-1:0]   speed_q;
	logic [IVL_W-1:0]     interval_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic                 dir_q;
	logic                 braking_q;
	logic                 moving_q;
	logic                 stepped_q;
	logic                 out_valid_q;

	// Captured item and registered product
	logic                 op_q;
	logic [POS_W-1:0]     target_q;
	logic [PROD_W-1:0]    prod_q;

	logic [ELAPSED_W-1:0] elapsed_inc;
	logic [PW-1:0]        cur_x, goal_x, raw, gap_dist, tgt_x;
	logic                 wanted;
	logic [POS_W-1:0]     goal_clamped;
	logic signed [SPEED_W+1:0] s_base, s_calc, min_s, max_s;
	logic                 brake_ends;
	logic [SPEED_W-1:0]   speed_next;
	logic                 dir_next;
	logic [POS_W-1:0]     cur_next;
	logic [SPEED_W-1:0]   div_in;
	logic                 div_done;
	logic [IVL_W-1:0]     div_quo;

	always_comb begin
		cur_x  = {1'b0, cur_q};
		goal_x = {1'b0, goal_q};
		if (goal_x > cur_x) begin
			raw    = goal_x - cur_x;
			wanted = !(raw > HALF);
		end else begin
			raw    = cur_x - goal_x;
			wanted = raw > HALF;
		end
		gap_dist = (raw > HALF) ? POS_N - raw : raw;
	end

	assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;

	// Target clamp: negative goes to zero, beyond the circle to the last position
	always_comb begin
		tgt_x = {1'b0, target_q};
		if (target_q[POS_W-1])
			goal_clamped = '0;
		else if (tgt_x > POS_LAST)
			goal_clamped = POS_LAST[POS_W-1:0];
		else
			goal_clamped = target_q;
	end

	// Ramp: brake, decelerate or accelerate, then clamp to the limits; also the next position
	always_comb begin
		s_base     = $signed({2'b00, speed_q});
		min_s      = $signed({2'b00, min_speed_q});
		max_s      = $signed({2'b00, max_speed_q});
		brake_ends = 1'b0;
		dir_next   = dir_q;
		s_calc     = s_base;
		if (braking_q) begin
			s_calc = s_base - $signed({6'b0, accel_step_q});
			if (s_calc <= min_s) begin
				brake_ends = 1'b1;
				dir_next   = wanted;
			end
		end else if (prod_q <= PROD_W'(speed_q)) begin
			s_calc = s_base - $signed({6'b0, accel_step_q});
		end else if (s_base < max_s) begin
			s_calc = s_base + $signed({6'b0, accel_step_q});
		end
		if (s_calc > max_s)
			speed_next = max_speed_q;
		else if (s_calc < min_s)
			speed_next = min_speed_q;
		else
			speed_next = s_calc[SPEED_W-1:0];
		if (dir_next)
			cur_next = (cur_x >= POS_LAST) ? '0 : cur_q + 1'b1;
		else
			cur_next = (cur_q == '0) ? POS_LAST[POS_W-1:0] : cur_q - 1'b1;
	end

	assign div_in = (speed_q == '0) ? SPEED_W'(1) : speed_q;

	srsg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.divisor  (div_in),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_speed_q  <= MIN_SPEED_RST;
			max_speed_q  <= MAX_SPEED_RST;
			accel_step_q <= ACCEL_STEP_RST;
			decel_div_q  <= DECEL_DIVISOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_SPEED:     min_speed_q  <= cfg_data;
				REG_MAX_SPEED:     max_speed_q  <= cfg_data;
				REG_ACCEL_STEP:    accel_step_q <= cfg_data[ACCEL_W-1:0];
				REG_DECEL_DIVISOR: decel_div_q  <= cfg_data[DIVISOR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			goal_q      <= '0;
			speed_q     <= MIN_SPEED_RST;
			interval_q  <= INTERVAL_RST;
			elapsed_q   <= '0;
			dir_q       <= 1'b1;
			braking_q   <= 1'b0;
			moving_q    <= 1'b0;
			stepped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec_set) begin
				goal_q    <= goal_clamped;
				moving_q  <= goal_clamped != cur_q;
				stepped_q <= 1'b0;
			end
			if (cmd.exec_tick) begin
				elapsed_q <= elapsed_inc;
				stepped_q <= 1'b0;
				if (cur_q == goal_q) begin
					moving_q <= 1'b0;
					speed_q  <= min_speed_q;
				end else if (!(elapsed_inc < {1'b0, interval_q})) begin
					// About to step: line up the direction or request a brake
					if (!moving_q)
						dir_q <= wanted;
					else if (!braking_q && wanted != dir_q)
						braking_q <= 1'b1;
				end
			end
			if (cmd.step) begin
				speed_q   <= speed_next;
				dir_q     <= dir_next;
				cur_q     <= cur_next;
				elapsed_q <= '0;
				stepped_q <= 1'b1;
				if (brake_ends)
					braking_q <= 1'b0;
			end
			if (cmd.load_interval)
				interval_q <= div_quo;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= in_op;
			target_q <= in_target;
		end
		if (cmd.mul)
			prod_q <= (gap_dist + 1'b1) * decel_div_q;
		if (cmd.emit) begin
			out_step_pulse <= stepped_q;
			out_direction  <= dir_q;
			out_moving     <= moving_q;
			out_position   <= cur_q;
		end
	end

	assign status.op_set       = op_q;
	assign status.at_target    = cur_q == goal_q;
	assign status.interval_due = !(elapsed_inc < {1'b0, interval_q});
	assign status.div_done     = div_done;
	assign status.out_free     = !out_valid_q || out_ready;
	assign out_valid           = out_valid_q;

endmodule
`default_nettype wire

// File: hdl/srsg_ctrl.sv
// Controller of the step generator: sequences one item through the datapath.
// Depends on srsg_pkg for the command and status structs.
`default_nettype none
module srsg_ctrl
	import srsg_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire srsg_status_t status,
	output srsg_cmd_t         cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_MUL,
		S_STEP,
		S_DSTART,
		S_DWAIT,
		S_OUT
	} state_t;

	state_t state_q;
	logic   do_step;

	assign in_ready = state_q == S_IDLE;
	assign do_step  = !status.op_set && !status.at_target && status.interval_due;

	always_comb begin
		cmd               = '0;
		cmd.capture       = (state_q == S_IDLE) && in_valid;
		cmd.exec_set      = (state_q == S_EXEC) && status.op_set;
		cmd.exec_tick     = (state_q == S_EXEC) && !status.op_set;
		cmd.mul           = state_q == S_MUL;
		cmd.step          = state_q == S_STEP;
		cmd.div_start     = state_q == S_DSTART;
		cmd.load_interval = (state_q == S_DWAIT) && status.div_done;
		cmd.emit          = (state_q == S_OUT) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:   if (in_valid) state_q <= S_EXEC;
				S_EXEC:   state_q <= do_step ? S_MUL : S_OUT;
				S_MUL:    state_q <= S_STEP;
				S_STEP:   state_q <= S_DSTART;
				S_DSTART: state_q <= S_DWAIT;
				S_DWAIT:  if (status.div_done) state_q <= S_OUT;
				S_OUT:    if (status.out_free) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
